/* sv/apq_pkg.sv */
// Shared types, codes and constants of the aging priority queue.
package apq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_ENQ = 2'd0,
    OP_EXT = 2'd1,
    OP_AGE = 2'd2,
    OP_NOP = 2'd3
  } apq_op_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } apq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } apq_state_e;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     eval;
    logic                     ins;
    logic                     ext;
    logic                     age;
    logic signed [DATA_W-1:0] key;
    logic signed [PRIO_W-1:0] prio;
    logic signed [PRIO_W-1:0] top;
  } apq_ctl_t;

endpackage

/* sv/apq_cell.sv */
// One storage cell of the sorted queue: holds an entry and moves it to a neighbor.
module apq_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  apq_pkg::apq_ctl_t                ctl_i,
  input  logic                             lft_vld_i,
  input  logic                             lft_ge_i,
  input  logic signed [apq_pkg::DATA_W-1:0] lft_pay_i,
  input  logic signed [apq_pkg::PRIO_W-1:0] lft_rank_i,
  input  logic                             rgt_vld_i,
  input  logic signed [apq_pkg::DATA_W-1:0] rgt_pay_i,
  input  logic signed [apq_pkg::PRIO_W-1:0] rgt_rank_i,
  input  logic                             shl_i,
  output logic                             vld_o,
  output logic                             ge_o,
  output logic                             match_o,
  output logic signed [apq_pkg::DATA_W-1:0] pay_o,
  output logic signed [apq_pkg::PRIO_W-1:0] rank_o,
  output logic signed [apq_pkg::DATA_W-1:0] pay_nxt_o,
  output logic signed [apq_pkg::PRIO_W-1:0] rank_nxt_o
);
  import apq_pkg::*;

  logic                     vld_q, vld_d;
  logic                     ge_q, ge_d;
  logic                     match_q, match_d;
  logic signed [DATA_W-1:0] pay_q, pay_d;
  logic signed [PRIO_W-1:0] rank_q, rank_d;

  // Local compares, captured in the evaluate cycle.
  always_comb begin
    ge_d    = ge_q;
    match_d = match_q;
    if (ctl_i.eval) begin
      ge_d    = vld_q && (rank_q >= ctl_i.prio);
      match_d = vld_q && (pay_q == ctl_i.key);
    end
  end

  always_comb begin
    vld_d  = vld_q;
    pay_d  = pay_q;
    rank_d = rank_q;
    priority if (ctl_i.ins && !ge_q) begin
      // Take the new entry at the boundary, else shift right from the left cell.
      vld_d = vld_q | lft_vld_i;
      if (lft_ge_i) begin
        pay_d  = ctl_i.key;
        rank_d = ctl_i.prio;
      end else begin
        pay_d  = lft_pay_i;
        rank_d = lft_rank_i;
      end
    end else if (ctl_i.ext && shl_i) begin
      vld_d  = rgt_vld_i;
      pay_d  = rgt_pay_i;
      rank_d = rgt_rank_i;
    end else if (ctl_i.age && vld_q && (rank_q < ctl_i.top)) begin
      rank_d = rank_q + PRIO_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      ge_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      ge_q    <= ge_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    rank_q <= rank_d;
  end

  assign vld_o      = vld_q;
  assign ge_o       = ge_q;
  assign match_o    = match_q;
  assign pay_o      = pay_q;
  assign rank_o     = rank_q;
  assign pay_nxt_o  = pay_d;
  assign rank_nxt_o = rank_d;

endmodule

/* sv/apq_prefix.sv */
// Inclusive prefix OR over the match flags of the cell row.
module apq_prefix #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic [DEPTH-1:0] match_i,
  output logic [DEPTH-1:0] incl_o,
  output logic             found_o
);
  import apq_pkg::*;

  localparam int unsigned Lvls = $clog2(DEPTH);

  logic [DEPTH-1:0] pre;

  // Log-depth scan: each level doubles the reach toward higher indexes.
  always_comb begin
    pre = match_i;
    for (int l = 0; l < Lvls; l++) begin
      pre = pre | (pre << (1 << l));
    end
  end

  assign incl_o  = pre;
  assign found_o = |match_i;

endmodule

/* sv/aging_priority_queue.sv */
// Top level of the aging priority queue: controller and row of cells.
//
// Bounded priority queue of DEPTH entries kept sorted by descending priority in a row
// of cells, ties in arrival order. An operation is a transaction taken at a rising
// edge where start is high and busy is low; it keeps busy high through an evaluate
// state, in which every cell compares its entry against the broadcast key and
// priority, and an apply state, in which every cell keeps, shifts or updates its
// entry from its neighbors. The result (status, count, head entry) appears on the
// result ports with done_o high for one cycle, in the same cycle that busy falls,
// and the next transaction can be taken at the edge that ends that cycle; no new
// transaction is taken while busy is high. The receiver cannot stall: sample the
// result when done_o is high. Enqueue into a full queue drops the item with
// status 1; extract of a key that is not present returns status 2 and leaves the
// queue unchanged; age raises every entry below the head's priority by one. Head
// fields read zero when the queue is empty. Count is the low five bits of the fill.
module aging_priority_queue #(
  parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op_i,
  input  logic signed [apq_pkg::DATA_W-1:0]  data_i,
  input  logic signed [apq_pkg::PRIO_W-1:0]  priority_req_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [apq_pkg::COUNT_W-1:0]        count_o,
  output logic signed [apq_pkg::DATA_W-1:0]  head_data_o,
  output logic signed [apq_pkg::PRIO_W-1:0]  head_priority_o
);
  import apq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  apq_state_e state_q, state_d;

  // Latched transaction
  apq_op_e                  op_q;
  logic signed [DATA_W-1:0] key_q;
  logic signed [PRIO_W-1:0] prio_q;

  logic [CntW-1:0]          cnt_q, cnt_d;

  // Result registers
  logic                     done_q;
  apq_status_e              status_q, status_d;
  logic [CntW+COUNT_W-1:0]  cnt_ext;
  logic [COUNT_W-1:0]       count_q;
  logic signed [DATA_W-1:0] head_pay_q, head_pay_d;
  logic signed [PRIO_W-1:0] head_rank_q, head_rank_d;

  // Cell row
  apq_ctl_t                 ctl;
  logic [DEPTH-1:0]         vld_vec;
  logic [DEPTH-1:0]         ge_vec;
  logic [DEPTH-1:0]         match_vec;
  logic [DEPTH-1:0]         incl_vec;
  logic                     found;
  logic signed [DATA_W-1:0] pay_arr  [DEPTH];
  logic signed [PRIO_W-1:0] rank_arr [DEPTH];
  logic signed [DATA_W-1:0] head_pay_nxt;
  logic signed [PRIO_W-1:0] head_rank_nxt;

  logic accept;
  logic apply;
  logic full;

  assign accept = start && !busy;
  assign apply  = (state_q == S_APPLY);
  assign full   = vld_vec[DEPTH-1];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) begin
        state_d = S_EVAL;
      end
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs: broadcast word, status and next fill count
  always_comb begin
    ctl      = '0;
    ctl.key  = key_q;
    ctl.prio = prio_q;
    ctl.top  = rank_arr[0];
    ctl.eval = (state_q == S_EVAL);
    status_d = ST_DONE;
    cnt_d    = cnt_q;
    if (apply) begin
      unique case (op_q)
        OP_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctl.ins = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        OP_EXT: begin
          if (found) begin
            ctl.ext = 1'b1;
            cnt_d   = cnt_q - CntW'(1);
          end else begin
            status_d = ST_NOTFOUND;
          end
        end
        OP_AGE:  ctl.age = 1'b1;
        OP_NOP:  ctl.age = 1'b0;
        default: ctl.age = 1'b0;
      endcase
    end
  end

  // Head of the queue after the transaction; zero when it leaves the queue empty
  always_comb begin
    head_pay_d  = head_pay_nxt;
    head_rank_d = head_rank_nxt;
    if (cnt_d == '0) begin
      head_pay_d  = '0;
      head_rank_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= apply;
    end
  end

  // Hold the transaction fields and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= apq_op_e'(op_i);
      key_q  <= data_i;
      prio_q <= priority_req_i;
    end
    if (apply) begin
      status_q    <= status_d;
      count_q     <= cnt_ext[COUNT_W-1:0];
      head_pay_q  <= head_pay_d;
      head_rank_q <= head_rank_d;
    end
  end

  assign cnt_ext = (CntW + COUNT_W)'(cnt_d);

  apq_prefix #(
    .DEPTH (DEPTH)
  ) u_prefix (
    .match_i (match_vec),
    .incl_o  (incl_vec),
    .found_o (found)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     lft_vld, lft_ge, rgt_vld;
    logic signed [DATA_W-1:0] lft_pay, rgt_pay;
    logic signed [PRIO_W-1:0] lft_rank, rgt_rank;
    logic signed [DATA_W-1:0] pay_nxt;
    logic signed [PRIO_W-1:0] rank_nxt;

    if (i == 0) begin : g_first
      // Treat the space before the head as a valid entry of higher priority.
      assign lft_vld  = 1'b1;
      assign lft_ge   = 1'b1;
      assign lft_pay  = '0;
      assign lft_rank = '0;
      assign head_pay_nxt  = pay_nxt;
      assign head_rank_nxt = rank_nxt;
    end else begin : g_mid
      assign lft_vld  = vld_vec[i-1];
      assign lft_ge   = ge_vec[i-1];
      assign lft_pay  = pay_arr[i-1];
      assign lft_rank = rank_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rgt_vld  = 1'b0;
      assign rgt_pay  = '0;
      assign rgt_rank = '0;
    end else begin : g_inner
      assign rgt_vld  = vld_vec[i+1];
      assign rgt_pay  = pay_arr[i+1];
      assign rgt_rank = rank_arr[i+1];
    end

    apq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .lft_vld_i  (lft_vld),
      .lft_ge_i   (lft_ge),
      .lft_pay_i  (lft_pay),
      .lft_rank_i (lft_rank),
      .rgt_vld_i  (rgt_vld),
      .rgt_pay_i  (rgt_pay),
      .rgt_rank_i (rgt_rank),
      .shl_i      (incl_vec[i]),
      .vld_o      (vld_vec[i]),
      .ge_o       (ge_vec[i]),
      .match_o    (match_vec[i]),
      .pay_o      (pay_arr[i]),
      .rank_o     (rank_arr[i]),
      .pay_nxt_o  (pay_nxt),
      .rank_nxt_o (rank_nxt)
    );
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign count_o         = count_q;
  assign head_data_o     = head_pay_q;
  assign head_priority_o = head_rank_q;

`ifndef NO_ASSERTIONS
  // Valid cells always form a contiguous run from the head.
  a_vld_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("valid cells not contiguous");

  // Fill count tracks the number of valid cells.
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(cnt_q))
    else $error("fill count disagrees with valid cells");

  // An accepted transaction yields its result strobe after the evaluate and apply states.
  a_result_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result strobe missing");

  // No result strobe without a transaction in flight.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_APPLY)
    else $error("spurious result strobe");
`endif

endmodule
